// ===== rtl/ammc_pkg.sv =====
`default_nettype none

package ammc_pkg;

    localparam int ACCEL_W = 20;
    localparam int SUM_W   = 25;
    localparam int THR_W   = 19;
    localparam int RECIP_W = 16;
    localparam int SCALE_W = 22;
    localparam int PROD_W  = 36;
    localparam int CFG_W   = 19;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 128;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 25'sh0FFFFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 25'sh1000000;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 22'h3FFFFF;

    localparam logic [THR_W-1:0]   THR_RESET   = 19'd9728;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 16'd6683;

    typedef enum logic [0:0] {
        REG_GRAVITY_THRESHOLD  = 1'b0,
        REG_GRAVITY_RECIPROCAL = 1'b1
    } cfg_reg_t;

    // per-stage load enables shared by all lanes
    typedef struct packed {
        logic accept;
        logic block_end;
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic upd;
    } ammc_ctl_t;

    typedef struct packed {
        logic                      ok;
        logic signed [ACCEL_W-1:0] avg;
        logic signed [ACCEL_W-1:0] bias;
        logic [PROD_W-1:0]         prod;
    } lane_res_t;

    // (prod + 1024) >> 11, clipped to 22 bits
    function automatic logic [SCALE_W-1:0] scale_round(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] r;
        r = {1'b0, p} + (PROD_W+1)'(1024);
        if (r[PROD_W:11] > (PROD_W-10)'(SCALE_MAX)) begin
            return SCALE_MAX;
        end
        return r[SCALE_W+10:11];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/accel_min_max_calibration.sv =====
`default_nettype none

// Accelerometer min/max calibration. Takes one three-axis sample per transfer
// and returns one result per sample, in order. Samples are summed per axis in
// blocks of BLOCK_LEN; at each block end the averages update the per-axis
// extremes, and when all extremes pass the threshold and |Z average| exceeds
// it, m_tuser (done) is high with bias and Q16 scale in m_tdata; otherwise the
// result is all zeros. Throughput is one sample per clock while the output
// is not stalled. There are six register stages: the lane pipeline
// (accumulate, reciprocal multiply, sign fix, min/max, span multiply), whose
// first stage loads on the input transfer, plus the merge/output register.
// Stalls on the output back up through the pipeline stage by stage, so empty
// stages still take input. Configuration writes are always ready and should
// only be issued while the block holds no samples.
module accel_min_max_calibration #(
    parameter int BLOCK_LEN = 20
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [63:0]  s_tdata,   // accel_x[19:0], accel_y[39:20], accel_z[59:40], zero pad
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [127:0] m_tdata,  // bias_x, bias_y, bias_z (20b each), scale_x, scale_y,
                                   // scale_z (22b each), zero pad
    output logic        m_tuser,   // done_res
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [0:0]   cfg_index,
    input  wire [18:0]  cfg_data
);
    import ammc_pkg::*;

    localparam int CNT_W = $clog2(BLOCK_LEN + 1);

    logic [THR_W-1:0]   thr_reg;
    logic [RECIP_W-1:0] recip_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [6:1]         v_reg;
    logic [5:1]         end_reg;
    logic [7:1]         rdy;
    logic               accept;
    logic               block_end;
    ammc_ctl_t          ctl;
    lane_res_t          res_x;
    lane_res_t          res_y;
    lane_res_t          res_z;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= THR_RESET;
            recip_reg <= RECIP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_GRAVITY_THRESHOLD:  thr_reg   <= cfg_data[THR_W-1:0];
                REG_GRAVITY_RECIPROCAL: recip_reg <= cfg_data[RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    // stage k may load when empty or when the stage after it moves
    always_comb begin
        rdy[7] = m_tready;
        for (int k = 6; k >= 1; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign s_tready  = rdy[1];
    assign accept    = s_tvalid && s_tready;
    assign block_end = (cnt_reg == CNT_W'(BLOCK_LEN - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept) begin
            cnt_reg <= block_end ? '0 : CNT_W'(cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg   <= '0;
            end_reg <= '0;
        end else begin
            if (rdy[1]) begin
                v_reg[1]   <= s_tvalid;
                end_reg[1] <= s_tvalid && block_end;
            end
            for (int k = 2; k <= 6; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            for (int k = 2; k <= 5; k++) begin
                if (rdy[k]) begin
                    end_reg[k] <= end_reg[k-1];
                end
            end
        end
    end

    always_comb begin
        ctl.accept    = accept;
        ctl.block_end = block_end;
        ctl.ld1       = rdy[1];
        ctl.ld2       = rdy[2];
        ctl.ld3       = rdy[3];
        ctl.ld4       = rdy[4];
        ctl.ld5       = rdy[5];
        ctl.upd       = rdy[4] && v_reg[3] && end_reg[3];
    end

    ammc_lane #(.BLOCK_LEN(BLOCK_LEN)) u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .accel   ($signed(s_tdata[19:0])),
        .thr     (thr_reg),
        .recip   (recip_reg),
        .res     (res_x)
    );

    ammc_lane #(.BLOCK_LEN(BLOCK_LEN)) u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .accel   ($signed(s_tdata[39:20])),
        .thr     (thr_reg),
        .recip   (recip_reg),
        .res     (res_y)
    );

    ammc_lane #(.BLOCK_LEN(BLOCK_LEN)) u_lane_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .accel   ($signed(s_tdata[59:40])),
        .thr     (thr_reg),
        .recip   (recip_reg),
        .res     (res_z)
    );

    ammc_merge u_merge (
        .aclk      (aclk),
        .ld        (rdy[6]),
        .block_end (end_reg[5]),
        .thr       (thr_reg),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_z     (res_z),
        .done_res  (m_tuser),
        .result    (m_tdata)
    );

    assign m_tvalid = v_reg[6];

`ifndef SYNTHESIS
    a_zero_when_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("result not zero without done");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(BLOCK_LEN - 1))
        else $error("sample count out of range");

    a_cnt_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && block_end) |=> (cnt_reg == '0))
        else $error("sample count did not clear at block end");

    a_upd_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.upd |-> (v_reg[3] && end_reg[3]))
        else $error("extreme update without block end");
`endif

endmodule

`default_nettype wire

// ===== rtl/ammc_lane.sv =====
`default_nettype none

module ammc_lane #(
    parameter int BLOCK_LEN = 20
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  ammc_pkg::ammc_ctl_t                  ctl,
    input  wire logic signed [ammc_pkg::ACCEL_W-1:0] accel,
    input  wire logic [ammc_pkg::THR_W-1:0]      thr,
    input  wire logic [ammc_pkg::RECIP_W-1:0]    recip,
    output ammc_pkg::lane_res_t                  res
);
    import ammc_pkg::*;

    // exact floor(x / BLOCK_LEN) for x < 2^25 via ceil reciprocal
    localparam int L_BITS = $clog2(BLOCK_LEN);
    localparam int SHIFT  = SUM_W + L_BITS;
    localparam int MUL_W  = 27;
    localparam logic [MUL_W-1:0] DIV_RECIP =
        MUL_W'(((64'd1 << SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));
    localparam int DP_W = SUM_W + MUL_W;

    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W:0]     acc_wide;
    logic signed [SUM_W-1:0]   acc_sat;
    logic signed [SUM_W-1:0]   p1_sum_reg;
    logic [SUM_W-1:0]          mag;
    logic [DP_W-1:0]           p2_prod_reg;
    logic                      p2_neg_reg;
    logic [DP_W-1:0]           shifted;
    logic [ACCEL_W:0]          qn;
    logic signed [ACCEL_W-1:0] p3_avg_reg;
    logic signed [ACCEL_W-1:0] max_reg;
    logic signed [ACCEL_W-1:0] min_reg;
    logic signed [ACCEL_W-1:0] max_next;
    logic signed [ACCEL_W-1:0] min_next;
    logic signed [ACCEL_W-1:0] p4_max_reg;
    logic signed [ACCEL_W-1:0] p4_min_reg;
    logic signed [ACCEL_W-1:0] p4_avg_reg;
    logic signed [ACCEL_W:0]   pair_sum;
    logic signed [ACCEL_W:0]   span;
    logic signed [ACCEL_W-1:0] thr_s;
    logic signed [ACCEL_W-1:0] neg_thr;
    logic                      ok_next;
    logic [PROD_W-1:0]         prod_next;
    lane_res_t                 p5_reg;

    // accumulate with saturation
    always_comb begin
        acc_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(accel);
        if (acc_wide > (SUM_W+1)'(SUM_MAX)) begin
            acc_sat = SUM_MAX;
        end else if (acc_wide < (SUM_W+1)'(SUM_MIN)) begin
            acc_sat = SUM_MIN;
        end else begin
            acc_sat = acc_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctl.accept) begin
            sum_reg <= ctl.block_end ? '0 : acc_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            p1_sum_reg <= acc_sat;
        end
    end

    // magnitude times reciprocal
    assign mag = p1_sum_reg[SUM_W-1] ? SUM_W'(-p1_sum_reg) : SUM_W'(p1_sum_reg);

    always_ff @(posedge aclk) begin
        if (ctl.ld2) begin
            p2_prod_reg <= DP_W'(mag) * DP_W'(DIV_RECIP);
            p2_neg_reg  <= p1_sum_reg[SUM_W-1];
        end
    end

    // truncate toward zero: restore the sign after the unsigned quotient
    always_comb begin
        shifted = p2_prod_reg >> SHIFT;
        qn = p2_neg_reg ? ((ACCEL_W+1)'(0) - shifted[ACCEL_W:0]) : shifted[ACCEL_W:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld3) begin
            p3_avg_reg <= qn[ACCEL_W-1:0];
        end
    end

    // running extremes of block averages
    assign max_next = (p3_avg_reg > max_reg) ? p3_avg_reg : max_reg;
    assign min_next = (p3_avg_reg < min_reg) ? p3_avg_reg : min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= '0;
            min_reg <= '0;
        end else if (ctl.upd) begin
            max_reg <= max_next;
            min_reg <= min_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld4) begin
            p4_max_reg <= max_next;
            p4_min_reg <= min_next;
            p4_avg_reg <= p3_avg_reg;
        end
    end

    // bias, span product and threshold check
    always_comb begin
        thr_s     = $signed({1'b0, thr});
        neg_thr   = ACCEL_W'(0) - thr_s;
        pair_sum  = (ACCEL_W+1)'(p4_max_reg) + (ACCEL_W+1)'(p4_min_reg);
        span      = (ACCEL_W+1)'(p4_max_reg) - (ACCEL_W+1)'(p4_min_reg);
        prod_next = PROD_W'(span[ACCEL_W-1:0]) * PROD_W'(recip);
        ok_next   = (p4_max_reg >= thr_s) && (p4_min_reg <= neg_thr);
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld5) begin
            p5_reg.ok   <= ok_next;
            p5_reg.avg  <= p4_avg_reg;
            p5_reg.bias <= pair_sum[ACCEL_W:1];
            p5_reg.prod <= prod_next;
        end
    end

    assign res = p5_reg;

endmodule

`default_nettype wire

// ===== rtl/ammc_merge.sv =====
`default_nettype none

module ammc_merge (
    input  wire                                   aclk,
    input  wire logic                             ld,
    input  wire logic                             block_end,
    input  wire logic [ammc_pkg::THR_W-1:0]       thr,
    input  ammc_pkg::lane_res_t                   res_x,
    input  ammc_pkg::lane_res_t                   res_y,
    input  ammc_pkg::lane_res_t                   res_z,
    output logic                                  done_res,
    output logic [ammc_pkg::OUT_TDATA_W-1:0]      result
);
    import ammc_pkg::*;

    logic [ACCEL_W:0]         az;
    logic                     done_next;
    logic [OUT_TDATA_W-1:0]   result_next;
    logic                     done_reg;
    logic [OUT_TDATA_W-1:0]   result_reg;

    always_comb begin
        az = res_z.avg[ACCEL_W-1] ? ((ACCEL_W+1)'(0) - (ACCEL_W+1)'(res_z.avg))
                                  : (ACCEL_W+1)'(res_z.avg);
        done_next = block_end && res_x.ok && res_y.ok && res_z.ok
                    && (az > (ACCEL_W+1)'(thr));
        result_next = '0;
        if (done_next) begin
            result_next = {2'b00,
                           scale_round(res_z.prod),
                           scale_round(res_y.prod),
                           scale_round(res_x.prod),
                           res_z.bias,
                           res_y.bias,
                           res_x.bias};
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign done_res = done_reg;
    assign result   = result_reg;

endmodule

`default_nettype wire
